### hw/rtl/hbmd_pkg.sv
// Shared types, constants and the arctangent table of the box distance core.
`default_nettype none

package hbmd_pkg;

    localparam int CORDIC_ITERS_DEF = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int ANG_W = 34;
    localparam int TRIG_FIX_LAT = 11;
    localparam int HAV_FIX_LAT = 38;

    localparam logic [30:0] RAD100_RESET = 31'd637100000;

    localparam logic signed [33:0] DEG90_U = 34'sd1800000000;
    localparam logic signed [33:0] DEG180_U = 34'sd3600000000;
    localparam logic signed [33:0] DEG360_U = 34'sd7200000000;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] DIV_D = 32'd3600000000;
    // floor(2^63 / DIV_D); the quotient estimate from it is at most two below the true one.
    localparam logic [31:0] DIV_RECIP = 32'd2562047788;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [63:0] ONE_Q60 = 64'd1152921504606846976;

    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        logic in_box;
        ang_t dlat_lo;
        ang_t dlat_hi;
        ang_t dlon_lo;
        ang_t dlon_hi;
        ang_t dbl_q;
        ang_t dbl_lo;
        ang_t dbl_hi;
    } item_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837830;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            10: r = 34'sd1048576;
            default: r = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hbmd_front.sv
// Front stage: takes a query transfer, classifies it and forms the angle arguments.
`default_nettype none

module hbmd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [30:0]   query_lat,
    input  wire logic signed [31:0]   query_lon,
    input  wire logic signed [30:0]   box_low_lat,
    input  wire logic signed [31:0]   box_low_lon,
    input  wire logic signed [30:0]   box_high_lat,
    input  wire logic signed [31:0]   box_high_lon,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hbmd_pkg::item_t           out_item
);

    logic vld_reg;
    hbmd_pkg::item_t item_reg;
    hbmd_pkg::item_t item_next;
    logic lat_in;
    logic lon_in;

    function automatic logic between(input logic signed [31:0] q, input logic signed [31:0] lo,
                                     input logic signed [31:0] hi);
        return ((q > lo) && (q < hi)) || ((q > hi) && (q < lo));
    endfunction

    assign in_ready = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item = item_reg;

    always_comb
    begin
        lat_in = between(32'(query_lat), 32'(box_low_lat), 32'(box_high_lat));
        lon_in = between(query_lon, box_low_lon, box_high_lon);
        item_next.in_box = lat_in && lon_in;
        item_next.dlat_lo = 34'(box_low_lat) - 34'(query_lat);
        item_next.dlat_hi = 34'(box_high_lat) - 34'(query_lat);
        item_next.dlon_lo = 34'(box_low_lon) - 34'(query_lon);
        item_next.dlon_hi = 34'(box_high_lon) - 34'(query_lon);
        item_next.dbl_q = 34'(query_lat) <<< 1;
        item_next.dbl_lo = 34'(box_low_lat) <<< 1;
        item_next.dbl_hi = 34'(box_high_lat) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hbmd_fifo.sv
// Short queue that decouples the classifying front from the distance pipeline.
`default_nettype none

module hbmd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hbmd_pkg::item_t din,
    output logic                 full,
    input  wire logic            pop,
    output hbmd_pkg::item_t      dout,
    output logic                 empty
);

    localparam int PTR_W = $clog2(hbmd_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(hbmd_pkg::FIFO_DEPTH + 1);

    hbmd_pkg::item_t mem [0:hbmd_pkg::FIFO_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full = (cnt_reg == CNT_W'(hbmd_pkg::FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(hbmd_pkg::FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(hbmd_pkg::FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hbmd_trig.sv
// Pipelined sine or cosine of an angle in half units of 1e-7 degree, Q30 result.
`default_nettype none

module hbmd_trig #(
    parameter int CORDIC_ITERS = hbmd_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic               is_cos,
    input  wire hbmd_pkg::ang_t     arg,
    output logic signed [31:0]      val
);

    logic signed [33:0] r1_reg;
    logic signed [33:0] r2_reg;
    logic signed [33:0] r3_reg;
    logic neg3_reg;
    logic [30:0] mag_reg;
    logic neg4_reg;
    logic sg4_reg;
    logic [62:0] n_reg;
    logic neg5_reg;
    logic sg5_reg;

    logic [63:0] recip_prod;
    logic [33:0] back_prod;
    logic [31:0] qe_reg;
    logic [33:0] nlo6_reg;
    logic [33:0] nlo7_reg;
    logic [31:0] qe7_reg;
    logic [33:0] pd_reg;
    logic [33:0] rm8_reg;
    logic [31:0] q8_reg;
    logic [33:0] rm9_reg;
    logic [31:0] q9_reg;
    logic [31:0] q10_reg;
    logic [4:0] sgp_reg;
    logic [4:0] ngp_reg;

    logic signed [33:0] cx_reg [0:CORDIC_ITERS-1];
    logic signed [33:0] cy_reg [0:CORDIC_ITERS-1];
    logic signed [33:0] cz_reg [0:CORDIC_ITERS-1];
    logic cng_reg [0:CORDIC_ITERS-1];

    logic signed [31:0] val_reg;

    assign val = val_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (arg >= hbmd_pkg::DEG360_U)
            begin
                r1_reg <= arg - hbmd_pkg::DEG360_U;
            end
            else if (arg <= -hbmd_pkg::DEG360_U)
            begin
                r1_reg <= arg + hbmd_pkg::DEG360_U;
            end
            else
            begin
                r1_reg <= arg;
            end

            if (r1_reg > hbmd_pkg::DEG180_U)
            begin
                r2_reg <= r1_reg - hbmd_pkg::DEG360_U;
            end
            else if (r1_reg < -hbmd_pkg::DEG180_U)
            begin
                r2_reg <= r1_reg + hbmd_pkg::DEG360_U;
            end
            else
            begin
                r2_reg <= r1_reg;
            end

            if (r2_reg > hbmd_pkg::DEG90_U)
            begin
                r3_reg <= hbmd_pkg::DEG180_U - r2_reg;
                neg3_reg <= 1'b1;
            end
            else if (r2_reg < -hbmd_pkg::DEG90_U)
            begin
                r3_reg <= -hbmd_pkg::DEG180_U - r2_reg;
                neg3_reg <= 1'b1;
            end
            else
            begin
                r3_reg <= r2_reg;
                neg3_reg <= 1'b0;
            end

            mag_reg <= (r3_reg < 0) ? 31'(-r3_reg) : 31'(r3_reg);
            sg4_reg <= (r3_reg < 0);
            neg4_reg <= neg3_reg;

            n_reg <= 63'(64'(mag_reg) * 64'(hbmd_pkg::PI_Q30) + 64'(hbmd_pkg::DEG90_U));
            sg5_reg <= sg4_reg;
            neg5_reg <= neg4_reg;
        end
    end

    // Rounded conversion to Q30 radians: a reciprocal estimate of the quotient by the
    // half-turn constant, then two compare and subtract corrections.
    assign recip_prod = 64'(n_reg[62:31]) * 64'(hbmd_pkg::DIV_RECIP);
    assign back_prod = 34'(qe_reg) * 34'(hbmd_pkg::DIV_D);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qe_reg <= recip_prod[63:32];
            nlo6_reg <= n_reg[33:0];

            pd_reg <= back_prod;
            nlo7_reg <= nlo6_reg;
            qe7_reg <= qe_reg;

            rm8_reg <= nlo7_reg - pd_reg;
            q8_reg <= qe7_reg;

            if (rm8_reg >= {2'b00, hbmd_pkg::DIV_D})
            begin
                rm9_reg <= rm8_reg - {2'b00, hbmd_pkg::DIV_D};
                q9_reg <= q8_reg + 32'd1;
            end
            else
            begin
                rm9_reg <= rm8_reg;
                q9_reg <= q8_reg;
            end

            if (rm9_reg >= {2'b00, hbmd_pkg::DIV_D})
            begin
                q10_reg <= q9_reg + 32'd1;
            end
            else
            begin
                q10_reg <= q9_reg;
            end

            sgp_reg <= {sgp_reg[3:0], sg5_reg};
            ngp_reg <= {ngp_reg[3:0], neg5_reg};
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_rot
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic ng_in;
        logic signed [33:0] dx;
        logic signed [33:0] dy;

        if (i == 0)
        begin : g_first
            logic signed [33:0] zq;
            assign zq = $signed({2'b00, q10_reg});
            assign x_in = hbmd_pkg::GAIN_Q30;
            assign y_in = '0;
            assign z_in = sgp_reg[4] ? -zq : zq;
            assign ng_in = ngp_reg[4];
        end
        else
        begin : g_rest
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign ng_in = cng_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_in >= 0)
                begin
                    cx_reg[i] <= x_in - dx;
                    cy_reg[i] <= y_in + dy;
                    cz_reg[i] <= z_in - hbmd_pkg::atan_q30(i);
                end
                else
                begin
                    cx_reg[i] <= x_in + dx;
                    cy_reg[i] <= y_in - dy;
                    cz_reg[i] <= z_in + hbmd_pkg::atan_q30(i);
                end
                cng_reg[i] <= ng_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!is_cos)
            begin
                val_reg <= cy_reg[CORDIC_ITERS-1][31:0];
            end
            else if (cng_reg[CORDIC_ITERS-1])
            begin
                val_reg <= 32'(-cx_reg[CORDIC_ITERS-1]);
            end
            else
            begin
                val_reg <= cx_reg[CORDIC_ITERS-1][31:0];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hbmd_hav.sv
// Haversine lane: combines trigonometric terms into one corner distance in centimeters.
`default_nettype none

module hbmd_hav #(
    parameter int CORDIC_ITERS = hbmd_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] sla,
    input  wire logic signed [31:0] slo,
    input  wire logic signed [31:0] c1,
    input  wire logic signed [31:0] c2,
    input  wire logic [30:0]        rad100,
    output logic [32:0]             dist_cm
);

    typedef struct packed {
        logic [60:0] rem;
        logic [30:0] root;
    } sq_t;

    function automatic sq_t sqrt_step(input sq_t s, input int k);
        sq_t r;
        logic [63:0] trial;
        trial = (64'(s.root) << (k + 1)) + (64'd1 << (2 * k));
        r = s;
        if (64'(s.rem) >= trial)
        begin
            r.rem = 61'(64'(s.rem) - trial);
            r.root = s.root | (31'd1 << k);
        end
        return r;
    endfunction

    logic signed [63:0] m1_prod;
    logic signed [63:0] m2_prod;
    logic signed [63:0] m3_prod;
    logic signed [63:0] sum4;

    logic signed [31:0] p_reg;
    logic signed [63:0] sq1_reg;
    logic signed [31:0] slo1_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] sq2_reg;
    logic signed [31:0] slo2_reg;
    logic signed [63:0] pr_reg;
    logic signed [63:0] sq3_reg;
    logic [60:0] a4_reg;
    logic [60:0] a5_reg;
    logic [60:0] b5_reg;

    sq_t sa_reg [0:30];
    sq_t sb_reg [0:30];

    logic signed [33:0] vx_reg [0:CORDIC_ITERS-1];
    logic signed [33:0] vy_reg [0:CORDIC_ITERS-1];
    logic signed [33:0] vz_reg [0:CORDIC_ITERS-1];

    logic signed [33:0] zc;
    logic [32:0] ang;
    logic [63:0] dp_reg;
    logic [63:0] rnd;
    logic [32:0] dist_reg;

    assign m1_prod = c1 * c2;
    assign m2_prod = p_reg * slo1_reg;
    assign m3_prod = t_reg * slo2_reg;
    assign sum4 = sq3_reg + pr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= m1_prod[61:30];
            sq1_reg <= sla * sla;
            slo1_reg <= slo;

            t_reg <= m2_prod[61:30];
            sq2_reg <= sq1_reg;
            slo2_reg <= slo1_reg;

            pr_reg <= m3_prod;
            sq3_reg <= sq2_reg;

            if (sum4 < 0)
            begin
                a4_reg <= '0;
            end
            else if (64'(sum4) > hbmd_pkg::ONE_Q60)
            begin
                a4_reg <= hbmd_pkg::ONE_Q60[60:0];
            end
            else
            begin
                a4_reg <= sum4[60:0];
            end

            a5_reg <= a4_reg;
            b5_reg <= hbmd_pkg::ONE_Q60[60:0] - a4_reg;
        end
    end

    for (genvar j = 0; j < 31; j++)
    begin : g_sqrt
        sq_t a_in;
        sq_t b_in;

        if (j == 0)
        begin : g_first
            assign a_in = '{rem: a5_reg, root: '0};
            assign b_in = '{rem: b5_reg, root: '0};
        end
        else
        begin : g_rest
            assign a_in = sa_reg[j-1];
            assign b_in = sb_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sa_reg[j] <= sqrt_step(a_in, 30 - j);
                sb_reg[j] <= sqrt_step(b_in, 30 - j);
            end
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_vec
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic signed [33:0] dx;
        logic signed [33:0] dy;

        if (i == 0)
        begin : g_first
            assign x_in = $signed({3'b000, sb_reg[30].root});
            assign y_in = $signed({3'b000, sa_reg[30].root});
            assign z_in = '0;
        end
        else
        begin : g_rest
            assign x_in = vx_reg[i-1];
            assign y_in = vy_reg[i-1];
            assign z_in = vz_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_in >= 0)
                begin
                    vx_reg[i] <= x_in + dx;
                    vy_reg[i] <= y_in - dy;
                    vz_reg[i] <= z_in + hbmd_pkg::atan_q30(i);
                end
                else
                begin
                    vx_reg[i] <= x_in - dx;
                    vy_reg[i] <= y_in + dy;
                    vz_reg[i] <= z_in - hbmd_pkg::atan_q30(i);
                end
            end
        end
    end

    assign zc = (vz_reg[CORDIC_ITERS-1] < 0) ? '0 : vz_reg[CORDIC_ITERS-1];
    assign ang = {zc[31:0], 1'b0};
    assign rnd = dp_reg + (64'd1 << 29);
    assign dist_cm = dist_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_reg <= 64'(ang) * 64'(rad100);
            dist_reg <= rnd[62:30];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/haversine_box_min_distance_core.sv
// Top level of the box minimum great-circle distance core.
`default_nettype none

// One query transfer is accepted per cycle while the queue is not full, and one result
// transfer leaves per cycle while m_tready is high. A query passes through the front
// register, the queue and the back pipeline (the fold and reciprocal conversion of
// the angle, two CORDIC chains and the bit-per-stage square roots). A stalled result
// freezes the back pipeline; the four-entry queue keeps taking queries meanwhile
// until it is full.
// A point strictly inside the box yields zero distance with the inside flag set.
module haversine_box_min_distance_core #(
    parameter int CORDIC_ITERS = hbmd_pkg::CORDIC_ITERS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [23:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // query_lat, query_lon, box_low_lat, box_low_lon, box_high_lat, box_high_lon
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // distance_cm
    output logic [39:0]       m_tdata,
    // inside_box
    output logic              m_tuser
);

    localparam int TRIG_LAT = hbmd_pkg::TRIG_FIX_LAT + CORDIC_ITERS;
    localparam int HAV_LAT = hbmd_pkg::HAV_FIX_LAT + CORDIC_ITERS;
    localparam int LAT = TRIG_LAT + HAV_LAT + 2;

    logic [30:0] rad100_reg;

    logic front_valid;
    hbmd_pkg::item_t front_item;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_push;
    logic fifo_pop;
    hbmd_pkg::item_t fifo_dout;

    logic en;
    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] ins_reg;

    logic signed [31:0] s_dlat_lo;
    logic signed [31:0] s_dlat_hi;
    logic signed [31:0] s_dlon_lo;
    logic signed [31:0] s_dlon_hi;
    logic signed [31:0] c_q;
    logic signed [31:0] c_lo;
    logic signed [31:0] c_hi;
    logic [32:0] d0;
    logic [32:0] d1;
    logic [32:0] d2;
    logic [32:0] d3;
    logic [32:0] mina_reg;
    logic [32:0] minb_reg;
    logic [32:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad100_reg <= hbmd_pkg::RAD100_RESET;
        end
        else if (cfg_we)
        begin
            rad100_reg <= (31'(cfg_wdata) << 6) + (31'(cfg_wdata) << 5) + (31'(cfg_wdata) << 2);
        end
    end

    hbmd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .query_lat    (s_tdata[30:0]),
        .query_lon    (s_tdata[62:31]),
        .box_low_lat  (s_tdata[93:63]),
        .box_low_lon  (s_tdata[125:94]),
        .box_high_lat (s_tdata[156:126]),
        .box_high_lon (s_tdata[188:157]),
        .out_valid    (front_valid),
        .out_ready    (!fifo_full),
        .out_item     (front_item)
    );

    assign fifo_push = front_valid && !fifo_full;
    assign en = !v_reg[LAT-1] || m_tready;
    assign fifo_pop = en && !fifo_empty;

    hbmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .din   (front_item),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .dout  (fifo_dout),
        .empty (fifo_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], fifo_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ins_reg <= {ins_reg[LAT-2:0], fifo_dout.in_box};
        end
    end

    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_sla_lo (
        .clk (clk), .en (en), .is_cos (1'b0), .arg (fifo_dout.dlat_lo), .val (s_dlat_lo)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_sla_hi (
        .clk (clk), .en (en), .is_cos (1'b0), .arg (fifo_dout.dlat_hi), .val (s_dlat_hi)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_slo_lo (
        .clk (clk), .en (en), .is_cos (1'b0), .arg (fifo_dout.dlon_lo), .val (s_dlon_lo)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_slo_hi (
        .clk (clk), .en (en), .is_cos (1'b0), .arg (fifo_dout.dlon_hi), .val (s_dlon_hi)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_cq (
        .clk (clk), .en (en), .is_cos (1'b1), .arg (fifo_dout.dbl_q), .val (c_q)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_clo (
        .clk (clk), .en (en), .is_cos (1'b1), .arg (fifo_dout.dbl_lo), .val (c_lo)
    );
    hbmd_trig #(.CORDIC_ITERS(CORDIC_ITERS)) u_trig_chi (
        .clk (clk), .en (en), .is_cos (1'b1), .arg (fifo_dout.dbl_hi), .val (c_hi)
    );

    hbmd_hav #(.CORDIC_ITERS(CORDIC_ITERS)) u_hav_ll (
        .clk (clk), .en (en), .sla (s_dlat_lo), .slo (s_dlon_lo), .c1 (c_q), .c2 (c_lo),
        .rad100 (rad100_reg), .dist_cm (d0)
    );
    hbmd_hav #(.CORDIC_ITERS(CORDIC_ITERS)) u_hav_hl (
        .clk (clk), .en (en), .sla (s_dlat_hi), .slo (s_dlon_lo), .c1 (c_q), .c2 (c_hi),
        .rad100 (rad100_reg), .dist_cm (d1)
    );
    hbmd_hav #(.CORDIC_ITERS(CORDIC_ITERS)) u_hav_lh (
        .clk (clk), .en (en), .sla (s_dlat_lo), .slo (s_dlon_hi), .c1 (c_q), .c2 (c_lo),
        .rad100 (rad100_reg), .dist_cm (d2)
    );
    hbmd_hav #(.CORDIC_ITERS(CORDIC_ITERS)) u_hav_hh (
        .clk (clk), .en (en), .sla (s_dlat_hi), .slo (s_dlon_hi), .c1 (c_q), .c2 (c_hi),
        .rad100 (rad100_reg), .dist_cm (d3)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mina_reg <= (d1 < d0) ? d1 : d0;
            minb_reg <= (d3 < d2) ? d3 : d2;
            if (ins_reg[LAT-2])
            begin
                dist_reg <= '0;
            end
            else
            begin
                dist_reg <= (minb_reg < mina_reg) ? minb_reg : mina_reg;
            end
        end
    end

    assign m_tvalid = v_reg[LAT-1];
    assign m_tdata = {7'b0, dist_reg};
    assign m_tuser = ins_reg[LAT-1];

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_full |-> !fifo_push)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_empty)
        else $error("queue read while empty");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline moved during a stall");

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("inside result carries a nonzero distance");

endmodule

`default_nettype wire
